// ===== rtl/bounded_list_engine_assert.svh =====
// Assertion macros for the list engine.
`ifndef BOUNDED_LIST_ENGINE_ASSERT_SVH
`define BOUNDED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define BLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define BLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// ===== rtl/ble_pkg.sv =====
package ble_pkg;

    localparam int CAPACITY    = 256;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int DATA_W      = 32;
    localparam int POS_W       = 8;
    localparam int OPCODE_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SWAP   = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                same_pos;
        logic [DATA_W-1:0]   value;
        logic [POS_W-1:0]    p1;
        logic [POS_W-1:0]    p2;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

endpackage

// ===== rtl/ble_ram.sv =====
module ble_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/ble_front.sv =====
module ble_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ble_pkg::OPCODE_W-1:0]   opcode,
    input  logic signed [ble_pkg::DATA_W-1:0] value,
    input  logic [ble_pkg::POS_W-1:0]      first_position,
    input  logic [ble_pkg::POS_W-1:0]      second_position,
    input  ble_pkg::q_stat_t               q_stat,
    output logic                           busy,
    output logic                           push,
    output ble_pkg::cmd_t                  push_cmd
);

    logic          hold_reg;
    logic          hold_next;
    ble_pkg::cmd_t cmd_reg;
    ble_pkg::cmd_t cmd_next;
    logic          take;

    assign busy     = hold_reg;
    assign take     = start && !hold_reg;
    assign push     = hold_reg && !q_stat.full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        hold_next = hold_reg;
        cmd_next  = cmd_reg;
        if (push)
        begin
            hold_next = 1'b0;
        end
        if (take)
        begin
            hold_next         = 1'b1;
            cmd_next.opcode   = opcode;
            cmd_next.same_pos = (first_position == second_position);
            cmd_next.value    = value;
            cmd_next.p1       = first_position;
            cmd_next.p2       = second_position;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg <= 1'b0;
        end
        else
        begin
            hold_reg <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== rtl/ble_queue.sv =====
module ble_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ble_pkg::cmd_t     push_cmd,
    input  logic              pop,
    output ble_pkg::cmd_t     head,
    output ble_pkg::q_stat_t  q_stat
);

    ble_pkg::cmd_t                 slot_reg [ble_pkg::QUEUE_DEPTH];
    logic [ble_pkg::QPTR_W-1:0]    wptr_reg;
    logic [ble_pkg::QPTR_W-1:0]    wptr_next;
    logic [ble_pkg::QPTR_W-1:0]    rptr_reg;
    logic [ble_pkg::QPTR_W-1:0]    rptr_next;
    logic [ble_pkg::QCNT_W-1:0]    fill_reg;
    logic [ble_pkg::QCNT_W-1:0]    fill_next;

    assign head         = slot_reg[rptr_reg];
    assign q_stat.valid = (fill_reg != '0);
    assign q_stat.full  = (fill_reg == ble_pkg::QCNT_W'(ble_pkg::QUEUE_DEPTH));

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == ble_pkg::QPTR_W'(ble_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == ble_pkg::QPTR_W'(ble_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/ble_back.sv =====
module ble_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ble_pkg::q_stat_t              q_stat,
    input  ble_pkg::cmd_t                 head,
    output logic                          pop,
    output logic                          ram_we,
    output logic [ble_pkg::ADDR_W-1:0]    ram_waddr,
    output logic [ble_pkg::DATA_W-1:0]    ram_wdata,
    output logic [ble_pkg::ADDR_W-1:0]    ram_raddr,
    input  logic [ble_pkg::DATA_W-1:0]    ram_rdata,
    output logic                          done,
    output logic                          success,
    output logic [ble_pkg::CNT_W-1:0]     entry_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SW_B  = 3'd1;
    localparam logic [2:0] S_SW_W1 = 3'd2;
    localparam logic [2:0] S_SW_W2 = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;

    logic [2:0]                  state_reg, state_next;
    logic [ble_pkg::CNT_W-1:0]   count_reg, count_next;
    ble_pkg::cmd_t               cmd_reg, cmd_next;
    logic [ble_pkg::DATA_W-1:0]  tmp_reg, tmp_next;
    logic [ble_pkg::ADDR_W-1:0]  scan_reg, scan_next;
    logic [ble_pkg::ADDR_W-1:0]  chk_reg, chk_next;
    logic                        pend_reg, pend_next;
    logic                        more_reg, more_next;
    logic [ble_pkg::CNT_W-1:0]   src_reg, src_next;
    logic [ble_pkg::ADDR_W-1:0]  wr_reg, wr_next;
    logic                        wpend_reg, wpend_next;
    logic                        res_valid_reg, res_valid_next;
    logic                        res_ok_reg, res_ok_next;
    logic [ble_pkg::CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    logic [ble_pkg::CNT_W-1:0]   h_p1, h_p2, c_p1, c_p2;
    logic [ble_pkg::ADDR_W-1:0]  h_phys1, c_phys1, c_phys2;
    logic [ble_pkg::CNT_W-1:0]   src_dec;

    assign h_p1    = ble_pkg::CNT_W'(head.p1);
    assign h_p2    = ble_pkg::CNT_W'(head.p2);
    assign c_p1    = ble_pkg::CNT_W'(cmd_reg.p1);
    assign c_p2    = ble_pkg::CNT_W'(cmd_reg.p2);
    assign h_phys1 = ble_pkg::ADDR_W'(count_reg - 1'b1 - h_p1);
    assign c_phys1 = ble_pkg::ADDR_W'(count_reg - 1'b1 - c_p1);
    assign c_phys2 = ble_pkg::ADDR_W'(count_reg - 1'b1 - c_p2);
    assign src_dec = src_reg - 1'b1;

    assign done        = res_valid_reg;
    assign success     = res_ok_reg;
    assign entry_count = res_cnt_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        tmp_next       = tmp_reg;
        scan_next      = scan_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        more_next      = more_reg;
        src_next       = src_reg;
        wr_next        = wr_reg;
        wpend_next     = wpend_reg;
        res_valid_next = 1'b0;
        res_ok_next    = res_ok_reg;
        res_cnt_next   = res_cnt_reg;
        pop            = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head;
                    unique case (head.opcode)
                        ble_pkg::OP_INSERT:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg < ble_pkg::CNT_W'(ble_pkg::CAPACITY))
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = ble_pkg::ADDR_W'(count_reg);
                                ram_wdata    = head.value;
                                count_next   = count_reg + 1'b1;
                                res_ok_next  = 1'b1;
                                res_cnt_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                res_ok_next  = 1'b0;
                                res_cnt_next = count_reg;
                            end
                        end
                        ble_pkg::OP_DELETE:
                        begin
                            res_valid_next = 1'b1;
                            if (count_reg != '0)
                            begin
                                count_next   = count_reg - 1'b1;
                                res_ok_next  = 1'b1;
                                res_cnt_next = count_reg - 1'b1;
                            end
                            else
                            begin
                                res_ok_next  = 1'b0;
                                res_cnt_next = count_reg;
                            end
                        end
                        ble_pkg::OP_SWAP:
                        begin
                            if (h_p1 < count_reg && h_p2 < count_reg && !head.same_pos)
                            begin
                                ram_raddr  = h_phys1;
                                state_next = S_SW_B;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_ok_next    = h_p1 < count_reg && head.same_pos;
                                res_cnt_next   = count_reg;
                            end
                        end
                        ble_pkg::OP_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                scan_next  = ble_pkg::ADDR_W'(count_reg - 1'b1);
                                more_next  = 1'b1;
                                pend_next  = 1'b0;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                res_valid_next = 1'b1;
                                res_ok_next    = 1'b0;
                                res_cnt_next   = count_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SW_B:
            begin
                ram_raddr  = c_phys2;
                tmp_next   = ram_rdata;
                state_next = S_SW_W1;
            end
            S_SW_W1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = c_phys1;
                ram_wdata  = ram_rdata;
                state_next = S_SW_W2;
            end
            S_SW_W2:
            begin
                ram_we         = 1'b1;
                ram_waddr      = c_phys2;
                ram_wdata      = tmp_reg;
                res_valid_next = 1'b1;
                res_ok_next    = 1'b1;
                res_cnt_next   = count_reg;
                state_next     = S_IDLE;
            end
            S_SCAN:
            begin
                // reads run one ahead of the compare
                priority if (pend_reg && ram_rdata == cmd_reg.value)
                begin
                    src_next   = ble_pkg::CNT_W'(chk_reg) + 1'b1;
                    wpend_next = 1'b0;
                    state_next = S_SHIFT;
                end
                else if (more_reg)
                begin
                    ram_raddr = scan_reg;
                    chk_next  = scan_reg;
                    pend_next = 1'b1;
                    if (scan_reg == '0)
                    begin
                        more_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg - 1'b1;
                    end
                end
                else
                begin
                    res_valid_next = 1'b1;
                    res_ok_next    = 1'b0;
                    res_cnt_next   = count_reg;
                    state_next     = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // close the gap: entry k takes entry k+1
                if (wpend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg;
                    ram_wdata = ram_rdata;
                end
                if (src_reg < count_reg)
                begin
                    ram_raddr  = ble_pkg::ADDR_W'(src_reg);
                    wr_next    = ble_pkg::ADDR_W'(src_dec);
                    wpend_next = 1'b1;
                    src_next   = src_reg + 1'b1;
                end
                else
                begin
                    wpend_next = 1'b0;
                    if (!wpend_reg)
                    begin
                        count_next     = count_reg - 1'b1;
                        res_valid_next = 1'b1;
                        res_ok_next    = 1'b1;
                        res_cnt_next   = count_reg - 1'b1;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            more_reg      <= 1'b0;
            wpend_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
            pend_reg      <= pend_next;
            more_reg      <= more_next;
            wpend_reg     <= wpend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        tmp_reg     <= tmp_next;
        scan_reg    <= scan_next;
        chk_reg     <= chk_next;
        src_reg     <= src_next;
        wr_reg      <= wr_next;
        res_ok_reg  <= res_ok_next;
        res_cnt_reg <= res_cnt_next;
    end

endmodule

// ===== rtl/bounded_list_engine.sv =====
// Ordered list of up to 256 signed 32-bit values, front at position 0.
// Command channel: drive opcode, value, first_position, second_position
// with start; the item is taken at a clock edge where start is high and
// busy is low. busy rises after each item is taken and stays high until
// the item enters the queue, which waits while the queue is full.
// Result channel: done pulses for one cycle with success and entry_count;
// there is no backpressure, so the result must be captured that cycle.
// A two-entry queue sits between the command register and the executor.
// Insert, delete front, a find on an empty list and a swap that moves
// nothing are finished in the idle state as they leave the queue. A swap
// reads both entries and writes them back crossed. Find and delete scans
// from the front and, on a match, moves each later entry forward one
// place; with no match the list stays as it was. The store serves one
// read and one write a cycle. The executor takes one item at a time,
// and items complete strictly in order.
// Reset empties the list and the queue; storage contents are not cleared.
module bounded_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ble_pkg::OPCODE_W-1:0]      opcode,
    input  logic signed [ble_pkg::DATA_W-1:0] value,
    input  logic [ble_pkg::POS_W-1:0]         first_position,
    input  logic [ble_pkg::POS_W-1:0]         second_position,
    output logic                              done,
    output logic                              success,
    output logic [ble_pkg::CNT_W-1:0]         entry_count
);

`include "bounded_list_engine_assert.svh"

    ble_pkg::q_stat_t             q_stat;
    ble_pkg::cmd_t                push_cmd;
    ble_pkg::cmd_t                head;
    logic                         push;
    logic                         pop;
    logic                         ram_we;
    logic [ble_pkg::ADDR_W-1:0]   ram_waddr;
    logic [ble_pkg::DATA_W-1:0]   ram_wdata;
    logic [ble_pkg::ADDR_W-1:0]   ram_raddr;
    logic [ble_pkg::DATA_W-1:0]   ram_rdata;

    ble_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .opcode          (opcode),
        .value           (value),
        .first_position  (first_position),
        .second_position (second_position),
        .q_stat          (q_stat),
        .busy            (busy),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    ble_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    ble_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .head        (head),
        .pop         (pop),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .done        (done),
        .success     (success),
        .entry_count (entry_count)
    );

    ble_ram #(
        .WIDTH (ble_pkg::DATA_W),
        .DEPTH (ble_pkg::CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    `BLE_ASSERT_NOW(a_no_push_full, push, !q_stat.full)
    `BLE_ASSERT_NOW(a_no_pop_empty, pop, q_stat.valid)
    `BLE_ASSERT_NEXT(a_busy_after_take, start && !busy, busy)
    `BLE_ASSERT_NOW(a_count_bound, done, entry_count <= ble_pkg::CNT_W'(ble_pkg::CAPACITY))

endmodule
